>>> rtl/atmr_pkg.sv
// Package for the 64-bit alarm timer: word types, register codes and the
// configuration bundle. Used by every module of the block; no dependencies.
package atmr_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned PRE_W   = 16;
  localparam int unsigned PADDR_W = 4;

  // Item kinds.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Timer registers reached through the item stream.
  localparam logic [3:0] REG_CTRL     = 4'd0;
  localparam logic [3:0] REG_LOAD_LO  = 4'd1;
  localparam logic [3:0] REG_LOAD_HI  = 4'd2;
  localparam logic [3:0] REG_LOAD_NOW = 4'd3;
  localparam logic [3:0] REG_LATCH    = 4'd4;
  localparam logic [3:0] REG_CNT_LO   = 4'd5;
  localparam logic [3:0] REG_CNT_HI   = 4'd6;
  localparam logic [3:0] REG_ALARM_LO = 4'd7;
  localparam logic [3:0] REG_ALARM_HI = 4'd8;
  localparam logic [3:0] REG_INT      = 4'd9;

  // Configuration register indexes on the APB port (byte address 4*i).
  localparam logic [1:0] CFG_PRESCALE  = 2'd0;
  localparam logic [1:0] CFG_COUNT_UP  = 2'd1;
  localparam logic [1:0] CFG_AUTO_RELD = 2'd2;
  localparam logic [1:0] CFG_INT_EN    = 2'd3;

  localparam logic [PRE_W-1:0] PRESCALE_RESET = 16'd1;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        reg_index;
    logic [DATA_W-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
    logic              alarm_hit;
  } out_word_t;

  typedef struct packed {
    logic [PRE_W-1:0] prescale_divider;
    logic             count_up;
    logic             auto_reload;
    logic             level_int_enable;
  } cfg_t;

endpackage

>>> rtl/alarm_timer_64bit.sv
// 64-bit alarm timer: ticks and bus words enter on one stream, one result each.
// The input register takes each word when it is accepted, and the result register
// takes its result when the word leaves the input register.
// Throughput: one word per cycle while out_stall is low, set by the update in atmr_core.
// Reset (rst, synchronous) clears all timer state and the pipeline, and returns
// configuration to divider 1, count up.
module alarm_timer_64bit import atmr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t      cfg;
  in_word_t  item;
  logic      item_valid;
  logic      advance;
  logic      accept;
  out_word_t result;

  atmr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A word leaves the input register when the result register is free or
  // its word is being taken this cycle.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  atmr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/atmr_cfg.sv
// APB configuration registers of the alarm timer.
// Depends on atmr_pkg for the register indexes and the cfg_t bundle.
module atmr_cfg import atmr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale_divider <= PRESCALE_RESET;
      cfg.count_up         <= 1'b1;
      cfg.auto_reload      <= 1'b0;
      cfg.level_int_enable <= 1'b0;
    end else if (wr_en) begin
      case (index)
        CFG_PRESCALE:  cfg.prescale_divider <= pwdata[PRE_W-1:0];
        CFG_COUNT_UP:  cfg.count_up         <= pwdata[0];
        CFG_AUTO_RELD: cfg.auto_reload      <= pwdata[0];
        CFG_INT_EN:    cfg.level_int_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (index)
      CFG_PRESCALE:  prdata = {{(DATA_W-PRE_W){1'b0}}, cfg.prescale_divider};
      CFG_COUNT_UP:  prdata = {{(DATA_W-1){1'b0}}, cfg.count_up};
      CFG_AUTO_RELD: prdata = {{(DATA_W-1){1'b0}}, cfg.auto_reload};
      CFG_INT_EN:    prdata = {{(DATA_W-1){1'b0}}, cfg.level_int_enable};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/atmr_core.sv
// Timer state and the state update for one word: prescaler, counter,
// bus registers and alarm comparator. Depends on atmr_pkg.
module atmr_core import atmr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_word_t  item,
  output out_word_t result
);

  logic [COUNT_W-1:0] count_value, count_value_next, count_mid;
  logic [PRE_W-1:0]   prescale_count, prescale_count_next;
  logic [COUNT_W-1:0] load_value, load_value_next;
  logic [COUNT_W-1:0] alarm_value, alarm_value_next;
  logic [COUNT_W-1:0] latched_count, latched_count_next;
  logic               run_enable, run_enable_next;
  logic               alarm_enable, alarm_enable_next, alarm_en_mid;
  logic               int_status, int_status_next, int_mid;

  logic [PRE_W:0]     div_full;
  logic [PRE_W:0]     pre_inc;
  logic               wrap;
  logic               hit;
  logic [DATA_W-1:0]  rd;

  // Divider 0 means 65536, and 1 acts as 2.
  always_comb begin
    if (cfg.prescale_divider == '0) begin
      div_full = {1'b1, {PRE_W{1'b0}}};
    end else if (cfg.prescale_divider == PRESCALE_RESET) begin
      div_full = (PRE_W+1)'(2);
    end else begin
      div_full = {1'b0, cfg.prescale_divider};
    end
    pre_inc = {1'b0, prescale_count} + (PRE_W+1)'(1);
    wrap    = (pre_inc >= div_full);
  end

  always_comb begin
    count_mid          = count_value;
    prescale_count_next = prescale_count;
    load_value_next    = load_value;
    alarm_value_next   = alarm_value;
    latched_count_next = latched_count;
    run_enable_next    = run_enable;
    alarm_en_mid       = alarm_enable;
    int_mid            = int_status;
    rd                 = '0;

    case (item.op)
      OP_TICK: begin
        if (run_enable) begin
          if (wrap) begin
            prescale_count_next = '0;
            count_mid = cfg.count_up ? count_value + COUNT_W'(1)
                                     : count_value - COUNT_W'(1);
          end else begin
            prescale_count_next = pre_inc[PRE_W-1:0];
          end
        end
      end
      OP_WRITE: begin
        case (item.reg_index)
          REG_CTRL: begin
            run_enable_next = item.write_data[0];
            alarm_en_mid    = item.write_data[1];
          end
          REG_LOAD_LO:  load_value_next[DATA_W-1:0]        = item.write_data;
          REG_LOAD_HI:  load_value_next[COUNT_W-1:DATA_W]  = item.write_data;
          REG_LOAD_NOW: count_mid = load_value;
          REG_LATCH:    latched_count_next = count_value;
          REG_ALARM_LO: alarm_value_next[DATA_W-1:0]       = item.write_data;
          REG_ALARM_HI: alarm_value_next[COUNT_W-1:DATA_W] = item.write_data;
          REG_INT:      int_mid = 1'b0;
          default: ;
        endcase
      end
      OP_READ: begin
        case (item.reg_index)
          REG_CTRL:     rd = {{(DATA_W-2){1'b0}}, alarm_enable, run_enable};
          REG_LOAD_LO:  rd = load_value[DATA_W-1:0];
          REG_LOAD_HI:  rd = load_value[COUNT_W-1:DATA_W];
          REG_CNT_LO:   rd = latched_count[DATA_W-1:0];
          REG_CNT_HI:   rd = latched_count[COUNT_W-1:DATA_W];
          REG_ALARM_LO: rd = alarm_value[DATA_W-1:0];
          REG_ALARM_HI: rd = alarm_value[COUNT_W-1:DATA_W];
          REG_INT:      rd = {{(DATA_W-1){1'b0}}, int_status};
          default:      rd = '0;
        endcase
      end
      default: ;
    endcase

    // The comparator sees the state after this word's own update.
    hit               = alarm_en_mid && (count_mid == alarm_value_next);
    count_value_next  = (hit && cfg.auto_reload) ? load_value_next : count_mid;
    alarm_enable_next = hit ? 1'b0 : alarm_en_mid;
    int_status_next   = hit ? 1'b1 : int_mid;

    result.read_data = rd;
    result.irq_level = int_status_next && cfg.level_int_enable;
    result.alarm_hit = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      prescale_count <= '0;
      load_value     <= '0;
      alarm_value    <= '0;
      latched_count  <= '0;
      run_enable     <= 1'b0;
      alarm_enable   <= 1'b0;
      int_status     <= 1'b0;
    end else if (step) begin
      count_value    <= count_value_next;
      prescale_count <= prescale_count_next;
      load_value     <= load_value_next;
      alarm_value    <= alarm_value_next;
      latched_count  <= latched_count_next;
      run_enable     <= run_enable_next;
      alarm_enable   <= alarm_enable_next;
      int_status     <= int_status_next;
    end
  end

  a_hit_disarms: assert property (@(posedge clk) disable iff (rst)
    step && result.alarm_hit |=> !alarm_enable && int_status)
    else $error("alarm match did not disarm the alarm and set the status");

  a_idle_holds_count: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(count_value) && $stable(prescale_count))
    else $error("timer state moved without a word");

  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    step && item.op == OP_TICK && !run_enable && !alarm_enable |=>
      $stable(count_value) && $stable(prescale_count))
    else $error("stopped timer counted a tick");

  a_hit_needs_arm: assert property (@(posedge clk) disable iff (rst)
    step && result.alarm_hit && !(item.op == OP_WRITE && item.reg_index == REG_CTRL)
      |-> alarm_enable)
    else $error("alarm match while the alarm was not armed");

endmodule

>>> dv/alarm_timer_64bit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for alarm_timer_64bit: streams tick and register words,
// predicts each result word in step with the block and programs the APB settings.
// Depends on atmr_pkg and the alarm_timer_64bit RTL.
module alarm_timer_64bit_tb;
  import atmr_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int IDLE_PERCENT   = 37;
  localparam int PHASE_WORDS    = 170;
  localparam int NUM_PHASES     = 8;
  localparam int MAX_REPORTS    = 10;

  // Codes the package leaves unnamed: an undefined op and an unmapped register.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [3:0] REG_UNUSED = 4'hF;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0]  pwdata    = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Predicted timer state and the configuration it runs under.
  logic [63:0] tmr_count;
  logic [63:0] tmr_load;
  logic [63:0] tmr_alarm;
  logic [63:0] tmr_latched;
  logic [15:0] tmr_prescale;
  logic        tmr_run;
  logic        tmr_alarm_en;
  logic        tmr_int;
  cfg_t        cur_cfg;

  in_word_t  queued_timer_ops[$];
  out_word_t predicted_timer_outs[$];

  logic in_taken      = 1'b0;
  bit   quiet_stretch = 1'b0;
  int   words_queued    = 0;
  int   words_sent      = 0;
  int   results_checked = 0;
  int   alarm_hits      = 0;
  int   error_count     = 0;
  int   cycle_count     = 0;
  int   settings_used   = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  alarm_timer_64bit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic int tick_period(logic [15:0] divider);
    if (divider == 16'd0) return 65536;
    if (divider == 16'd1) return 2;
    return int'(divider);
  endfunction

  task automatic advance_timer(input in_word_t w, output out_word_t r);
    logic [31:0] rd;
    logic        hit;
    rd  = '0;
    hit = 1'b0;
    if (w.op == OP_TICK) begin
      if (tmr_run) begin
        if (int'(tmr_prescale) + 1 >= tick_period(cur_cfg.prescale_divider)) begin
          tmr_prescale = '0;
          tmr_count = cur_cfg.count_up ? tmr_count + 64'd1 : tmr_count - 64'd1;
        end else begin
          tmr_prescale = tmr_prescale + 16'd1;
        end
      end
    end else if (w.op == OP_WRITE) begin
      case (w.reg_index)
        REG_CTRL: begin
          tmr_run      = w.write_data[0];
          tmr_alarm_en = w.write_data[1];
        end
        REG_LOAD_LO:  tmr_load[31:0]   = w.write_data;
        REG_LOAD_HI:  tmr_load[63:32]  = w.write_data;
        REG_LOAD_NOW: tmr_count        = tmr_load;
        REG_LATCH:    tmr_latched      = tmr_count;
        REG_ALARM_LO: tmr_alarm[31:0]  = w.write_data;
        REG_ALARM_HI: tmr_alarm[63:32] = w.write_data;
        REG_INT:      tmr_int          = 1'b0;
        default: ;
      endcase
    end else if (w.op == OP_READ) begin
      case (w.reg_index)
        REG_CTRL:     rd = {30'd0, tmr_alarm_en, tmr_run};
        REG_LOAD_LO:  rd = tmr_load[31:0];
        REG_LOAD_HI:  rd = tmr_load[63:32];
        REG_CNT_LO:   rd = tmr_latched[31:0];
        REG_CNT_HI:   rd = tmr_latched[63:32];
        REG_ALARM_LO: rd = tmr_alarm[31:0];
        REG_ALARM_HI: rd = tmr_alarm[63:32];
        REG_INT:      rd = {31'd0, tmr_int};
        default:      rd = '0;
      endcase
    end
    // The comparator sees the state this word left behind, whatever its kind.
    if (tmr_alarm_en && tmr_count == tmr_alarm) begin
      hit          = 1'b1;
      tmr_int      = 1'b1;
      tmr_alarm_en = 1'b0;
      if (cur_cfg.auto_reload) tmr_count = tmr_load;
    end
    r.read_data = rd;
    r.irq_level = tmr_int & cur_cfg.level_int_enable;
    r.alarm_hit = hit;
  endtask

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      note_error($sformatf("%s of result %0d: expected %h, got %h",
                           name, results_checked, want, got));
  endtask

  // Input driver: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (queued_timer_ops.size() != 0 &&
          (quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        in_data  <= queued_timer_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin : monitor
    out_word_t want;
    out_word_t next_want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (predicted_timer_outs.size() == 0) begin
          note_error($sformatf("result word %h arrived with none expected", out_data));
        end else begin
          want = predicted_timer_outs.pop_front();
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("irq_level", 32'(want.irq_level), 32'(out_data.irq_level));
          check_field("alarm_hit", 32'(want.alarm_hit), 32'(out_data.alarm_hit));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        advance_timer(in_data, next_want);
        predicted_timer_outs.push_back(next_want);
        words_sent++;
        if (next_want.alarm_hit) alarm_hits++;
      end
    end
    in_taken <= !rst && in_valid && !in_stall;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, predicted_timer_outs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_word(logic [1:0] op, logic [3:0] idx, logic [31:0] data);
    in_word_t w;
    w.op         = op;
    w.reg_index  = idx;
    w.write_data = data;
    queued_timer_ops.push_back(w);
    words_queued++;
  endtask

  // Counts near the 32-bit carry, the 64-bit wrap and zero, or anywhere.
  function automatic logic [63:0] pick_count();
    case ($urandom_range(0, 4))
      0:       return {$urandom, $urandom};
      1:       return {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 3)};
      2:       return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
      3:       return 64'($urandom_range(0, 3));
      default: return {$urandom, 32'($urandom_range(0, 3))};
    endcase
  endfunction

  task automatic queue_random_sequence(cfg_t c);
    logic [63:0] start_val;
    logic [63:0] target;
    int          steps;
    int          period;
    period = tick_period(c.prescale_divider);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // Load a known count, arm the alarm a few steps away and tick up to it.
        steps     = (period > 64) ? 0 : $urandom_range(0, 4);
        start_val = pick_count();
        target    = c.count_up ? start_val + 64'(steps) : start_val - 64'(steps);
        push_word(OP_WRITE, REG_LOAD_LO, start_val[31:0]);
        push_word(OP_WRITE, REG_LOAD_HI, start_val[63:32]);
        push_word(OP_WRITE, REG_ALARM_LO, target[31:0]);
        push_word(OP_WRITE, REG_ALARM_HI, target[63:32]);
        push_word(OP_WRITE, REG_CTRL,
                  {30'($urandom), 1'b1, (steps == 0) ? 1'($urandom) : 1'b1});
        push_word(OP_WRITE, REG_LOAD_NOW, $urandom);
        repeat (steps * period + $urandom_range(0, 2))
          push_word(OP_TICK, 4'($urandom), $urandom);
        if ($urandom_range(0, 1)) begin
          push_word(OP_READ, REG_INT, $urandom);
          push_word(OP_WRITE, REG_INT, $urandom);
        end
      end
      4, 5: begin
        push_word(OP_WRITE, REG_LATCH, $urandom);
        push_word(OP_READ, REG_CNT_LO, $urandom);
        push_word(OP_READ, REG_CNT_HI, $urandom);
      end
      6, 7: repeat ($urandom_range(1, 12)) push_word(OP_TICK, 4'($urandom), $urandom);
      8:       push_word(OP_READ, 4'($urandom), $urandom);
      default: repeat ($urandom_range(1, 3)) push_word(2'($urandom), 4'($urandom), $urandom);
    endcase
  endtask

  task automatic write_cfg_reg(logic [1:0] index, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Returns on a rising edge once every sent word has been answered.
  task automatic wait_until_drained();
    do begin
      @(posedge clk);
      #1;
    end while (queued_timer_ops.size() != 0 || in_valid ||
               predicted_timer_outs.size() != 0);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_t next_cfg;
    int   phase_end;
    bit   paused_once;
    paused_once  = 1'b0;
    tmr_count    = '0;
    tmr_load     = '0;
    tmr_alarm    = '0;
    tmr_latched  = '0;
    tmr_prescale = '0;
    tmr_run      = 1'b0;
    tmr_alarm_en = 1'b0;
    tmr_int      = 1'b0;
    cur_cfg      = '{PRESCALE_RESET, 1'b1, 1'b0, 1'b0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset settings (divider 1 acts as 2).
    push_word(OP_READ, REG_CTRL, '0);
    push_word(OP_READ, REG_INT, 32'hFFFF_FFFF);
    push_word(OP_WRITE, REG_CTRL, 32'h0000_0001);
    repeat (4) push_word(OP_TICK, REG_CTRL, '0);
    push_word(OP_WRITE, REG_LATCH, 32'hFFFF_FFFF);
    push_word(OP_READ, REG_CNT_LO, '0);
    push_word(OP_READ, REG_CNT_HI, '0);
    push_word(OP_WRITE, REG_LOAD_LO, 32'hFFFF_FFFF);
    push_word(OP_WRITE, REG_LOAD_HI, 32'hFFFF_FFFF);
    push_word(OP_WRITE, REG_LOAD_NOW, '0);
    push_word(OP_WRITE, REG_CTRL, 32'h0000_0003);
    // The count wraps to zero and meets the alarm value left at reset.
    repeat (2) push_word(OP_TICK, REG_UNUSED, 32'hFFFF_FFFF);
    push_word(OP_READ, REG_INT, '0);
    push_word(OP_WRITE, REG_INT, '0);
    push_word(OP_READ, REG_INT, '0);
    push_word(OP_WRITE, REG_CNT_LO, 32'h1234_5678);
    push_word(OP_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
    push_word(OP_READ, REG_UNUSED, '0);
    push_word(OP_READ, REG_LATCH, '0);
    push_word(OP_READ, REG_LOAD_NOW, '0);
    push_word(OP_UNUSED, REG_CTRL, 32'hFFFF_FFFF);
    // Arming the alarm on a stopped timer that already sits on it matches at once.
    push_word(OP_WRITE, REG_CTRL, 32'h0000_0002);
    push_word(OP_READ, REG_CTRL, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_until_drained();
        case (ph)
          1:       next_cfg = '{16'd2, 1'b1, 1'b1, 1'b1};
          2:       next_cfg = '{16'd3, 1'b0, 1'b0, 1'b1};
          3:       next_cfg = '{16'd0, 1'b1, 1'b1, 1'b0};
          4:       next_cfg = '{16'hFFFF, 1'b0, 1'b1, 1'b1};
          5:       next_cfg = '{16'($urandom_range(4, 40)), 1'($urandom), 1'($urandom),
                                1'($urandom)};
          6:       next_cfg = '{16'd1, 1'b0, 1'b1, 1'b1};
          default: next_cfg = '{16'($urandom_range(1, 8)), 1'b1, 1'b0, 1'b1};
        endcase
        write_cfg_reg(CFG_PRESCALE, 32'(next_cfg.prescale_divider));
        write_cfg_reg(CFG_COUNT_UP, 32'(next_cfg.count_up));
        write_cfg_reg(CFG_AUTO_RELD, 32'(next_cfg.auto_reload));
        write_cfg_reg(CFG_INT_EN, 32'(next_cfg.level_int_enable));
        cur_cfg = next_cfg;
        settings_used++;
        @(posedge clk);
      end else begin
        next_cfg = cur_cfg;
      end
      quiet_stretch = (ph == 5);
      phase_end = words_queued + PHASE_WORDS;
      while (words_queued < phase_end) begin
        queue_random_sequence(next_cfg);
        // Once, hold the sender back until every word in flight has answered.
        if (ph == 2 && !paused_once && words_queued >= phase_end - PHASE_WORDS / 2) begin
          wait_until_drained();
          paused_once = 1'b1;
        end
      end
    end

    wait_until_drained();
    $display("Checked %0d result words for %0d words sent, %0d of them alarm matches,",
             results_checked, words_sent, alarm_hits);
    $display("across %0d timer settings in %0d cycles.", settings_used, cycle_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
